[src/psmr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psmr_pkg;

    localparam int BIAS_W   = 32;
    localparam int ELEM_W   = 16;
    localparam int WGT_W    = 16;
    localparam int PROD_W   = 32;
    localparam int PART_W   = 16;
    localparam int RESULT_W = 32;
    localparam int TOTAL_W  = 32;

    localparam int MAX_PART_SIZE_DEF = 65535;
    localparam logic [PART_W-1:0] PART_SIZE_RST = 16'd1024;

    // One item after the multiplier, on its way to the accumulator.
    typedef struct packed {
        logic                     first;
        logic                     last;
        logic signed [BIAS_W-1:0] bias;
        logic signed [PROD_W-1:0] product;
    } psmr_prod_t;

endpackage

`default_nettype wire

[src/psmr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface psmr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [psmr_pkg::BIAS_W-1:0]  bias_value;
    logic signed [psmr_pkg::ELEM_W-1:0]  element_value;
    logic signed [psmr_pkg::WGT_W-1:0]   weight_value;
    logic                                first_of_row;
    logic                                last_of_row;

    modport source (
        output valid, bias_value, element_value, weight_value, first_of_row, last_of_row,
        input  ready
    );
    modport sink (
        input  valid, bias_value, element_value, weight_value, first_of_row, last_of_row,
        output ready
    );
endinterface

interface psmr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psmr_pkg::RESULT_W-1:0] row_result;
    logic                                 row_clamped;
    logic        [psmr_pkg::TOTAL_W-1:0]  clamp_total;

    modport source (
        output valid, row_result, row_clamped, clamp_total,
        input  ready
    );
    modport sink (
        input  valid, row_result, row_clamped, clamp_total,
        output ready
    );
endinterface

`default_nettype wire

[src/partitioned_saturating_mac_row.sv]
// Saturating multiply-accumulate for one output row of a recurrent layer.
// The items channel carries one beat per row element: the signed element,
// its signed weight, the bias (used only on a beat marked first_of_row) and
// the first and last marks. The results channel carries one beat per row,
// sent for each beat marked last_of_row: the clamped 32-bit sum, a flag that
// a clamp changed the sum in this row, and a running clamp count that wraps.
// The sum is clamped to 32 bits after every part_size elements and at the
// row end. The user must write part_size through cfg_we and cfg_wdata only
// while no beat is in flight; the block does not enforce this. Zero or a
// value above MAX_PART_SIZE acts as MAX_PART_SIZE. One beat is taken every
// cycle while no row end waits on a stalled receiver. The pipeline is an
// input register, a product register and the accumulator with its result
// register. When the receiver stalls, the result holds and items keep
// flowing until the next row end reaches the accumulator. Reset clears the
// sum, the counters and all valid flags, and sets part_size to 1024.
`timescale 1ns / 1ps
`default_nettype none

module partitioned_saturating_mac_row #(
    parameter int MAX_PART_SIZE = psmr_pkg::MAX_PART_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [psmr_pkg::PART_W-1:0] cfg_wdata,
    psmr_in_if.sink                          items,
    psmr_out_if.source                       results
);

    logic                 p_valid;
    logic                 p_ready;
    psmr_pkg::psmr_prod_t p_data;

    psmr_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .p_valid (p_valid),
        .p_ready (p_ready),
        .p_data  (p_data)
    );

    psmr_accum #(
        .MAX_PART_SIZE (MAX_PART_SIZE)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .p_valid   (p_valid),
        .p_ready   (p_ready),
        .p_data    (p_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .results   (results)
    );

endmodule

`default_nettype wire

[src/psmr_mult.sv]
`timescale 1ns / 1ps
`default_nettype none

module psmr_mult (
    input  wire logic            clk,
    input  wire logic            rst_n,
    psmr_in_if.sink              items,
    output logic                 p_valid,
    input  wire logic            p_ready,
    output psmr_pkg::psmr_prod_t p_data
);

    localparam int PROD_W = psmr_pkg::PROD_W;

    logic                                a_v_reg;
    logic                                a_v_next;
    logic signed [psmr_pkg::BIAS_W-1:0]  a_bias_reg;
    logic signed [psmr_pkg::ELEM_W-1:0]  a_elem_reg;
    logic signed [psmr_pkg::WGT_W-1:0]   a_wgt_reg;
    logic                                a_first_reg;
    logic                                a_last_reg;

    logic                                b_v_reg;
    logic                                b_v_next;
    psmr_pkg::psmr_prod_t                b_data_reg;
    logic signed [psmr_pkg::PROD_W-1:0]  product;
    logic                                b_load;
    logic                                a_take;

    assign product = PROD_W'(a_elem_reg) * PROD_W'(a_wgt_reg);
    assign b_load  = a_v_reg && (!b_v_reg || p_ready);
    assign items.ready = !a_v_reg || b_load;
    assign a_take  = items.valid && items.ready;

    always_comb
    begin
        a_v_next = a_v_reg;
        if (a_take)
        begin
            a_v_next = 1'b1;
        end
        else if (b_load)
        begin
            a_v_next = 1'b0;
        end
        b_v_next = b_v_reg;
        if (b_load)
        begin
            b_v_next = 1'b1;
        end
        else if (p_ready)
        begin
            b_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            a_bias_reg  <= items.bias_value;
            a_elem_reg  <= items.element_value;
            a_wgt_reg   <= items.weight_value;
            a_first_reg <= items.first_of_row;
            a_last_reg  <= items.last_of_row;
        end
        if (b_load)
        begin
            b_data_reg.first   <= a_first_reg;
            b_data_reg.last    <= a_last_reg;
            b_data_reg.bias    <= a_bias_reg;
            b_data_reg.product <= product;
        end
    end

    assign p_valid = b_v_reg;
    assign p_data  = b_data_reg;

endmodule

`default_nettype wire

[src/psmr_accum.sv]
`timescale 1ns / 1ps
`default_nettype none

module psmr_accum #(
    parameter int MAX_PART_SIZE = psmr_pkg::MAX_PART_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        p_valid,
    output logic                             p_ready,
    input  wire psmr_pkg::psmr_prod_t        p_data,
    input  wire logic                        cfg_we,
    input  wire logic [psmr_pkg::PART_W-1:0] cfg_wdata,
    psmr_out_if.source                       results
);

    localparam int CNT_W  = $clog2(MAX_PART_SIZE + 1);
    localparam int SUM_W  = CNT_W + 32;
    localparam int PART_W = psmr_pkg::PART_W;
    localparam logic [PART_W-1:0] MAX_PS = PART_W'(MAX_PART_SIZE);
    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-32){1'b1}}, 32'h8000_0000};

    logic [PART_W-1:0]                     part_size_reg;
    logic [PART_W-1:0]                     eff;

    logic signed [SUM_W-1:0]               sum_reg;
    logic signed [SUM_W-1:0]               sum_next;
    logic [CNT_W-1:0]                      cnt_reg;
    logic [CNT_W-1:0]                      cnt_next;
    logic                                  flag_reg;
    logic                                  flag_next;
    logic [psmr_pkg::TOTAL_W-1:0]          clamp_cnt_reg;
    logic [psmr_pkg::TOTAL_W-1:0]          clamp_cnt_next;

    logic                                  o_v_reg;
    logic                                  o_v_next;
    logic signed [psmr_pkg::RESULT_W-1:0]  o_result_reg;
    logic                                  o_clamped_reg;
    logic [psmr_pkg::TOTAL_W-1:0]          o_total_reg;

    logic                                  fire;
    logic signed [SUM_W-1:0]               sum_base;
    logic signed [SUM_W-1:0]               sum_add;
    logic [CNT_W-1:0]                      cnt_inc;
    logic                                  flag_row;
    logic                                  hit;
    logic                                  over_hi;
    logic                                  over_lo;
    logic                                  changed;

    assign eff = (part_size_reg == '0 || part_size_reg > MAX_PS) ? MAX_PS : part_size_reg;

    assign p_ready = !p_data.last || !o_v_reg || results.ready;
    assign fire    = p_valid && p_ready;

    always_comb
    begin
        sum_base = p_data.first ? SUM_W'(p_data.bias) : sum_reg;
        sum_add  = sum_base + SUM_W'(p_data.product);
        cnt_inc  = (p_data.first ? '0 : cnt_reg) + CNT_W'(1);
        flag_row = p_data.first ? 1'b0 : flag_reg;
        hit      = PART_W'(cnt_inc) >= eff;
        over_hi  = sum_add > SAT_HI;
        over_lo  = sum_add < SAT_LO;
        changed  = (hit || p_data.last) && (over_hi || over_lo);

        sum_next = sum_add;
        if (changed)
        begin
            sum_next = over_hi ? SAT_HI : SAT_LO;
        end
        flag_next      = p_data.last ? 1'b0 : (flag_row || changed);
        cnt_next       = (hit || p_data.last) ? '0 : cnt_inc;
        clamp_cnt_next = clamp_cnt_reg + {{(psmr_pkg::TOTAL_W-1){1'b0}}, changed};

        o_v_next = o_v_reg;
        if (fire && p_data.last)
        begin
            o_v_next = 1'b1;
        end
        else if (results.ready)
        begin
            o_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_size_reg <= psmr_pkg::PART_SIZE_RST;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            clamp_cnt_reg <= '0;
            o_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                part_size_reg <= cfg_wdata;
            end
            if (fire)
            begin
                sum_reg       <= sum_next;
                cnt_reg       <= cnt_next;
                flag_reg      <= flag_next;
                clamp_cnt_reg <= clamp_cnt_next;
            end
            o_v_reg <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && p_data.last)
        begin
            o_result_reg  <= sum_next[psmr_pkg::RESULT_W-1:0];
            o_clamped_reg <= flag_row || changed;
            o_total_reg   <= clamp_cnt_next;
        end
    end

    assign results.valid       = o_v_reg;
    assign results.row_result  = o_result_reg;
    assign results.row_clamped = o_clamped_reg;
    assign results.clamp_total = o_total_reg;

    a_sum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (p_data.last || hit) |=> (sum_reg <= SAT_HI && sum_reg >= SAT_LO))
        else $error("Sum left the 32-bit range after a clamp point.");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(MAX_PART_SIZE))
        else $error("Part counter reached the maximum part size.");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        clamp_cnt_reg == $past(clamp_cnt_reg)
        || clamp_cnt_reg == $past(clamp_cnt_reg) + {{(psmr_pkg::TOTAL_W-1){1'b0}}, 1'b1})
        else $error("Clamp count moved by more than one.");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(fire && p_data.last))
        else $error("Result beat appeared without a row end.");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int ELEM_BITS = psmr_pkg::ELEM_W;
    localparam int WGT_BITS  = psmr_pkg::WGT_W;

    typedef struct packed {
        logic signed [psmr_pkg::BIAS_W-1:0] bias;
        logic signed [psmr_pkg::ELEM_W-1:0] element;
        logic signed [psmr_pkg::WGT_W-1:0]  weight;
        logic                               first;
        logic                               last;
    } mac_item_t;

    typedef struct packed {
        logic signed [psmr_pkg::RESULT_W-1:0] sum;
        logic                                 clamped;
        logic [psmr_pkg::TOTAL_W-1:0]         total;
    } row_out_t;

    typedef struct packed {
        mac_item_t stim;
        logic      typed;
        row_out_t  want;
    } directed_row_t;

    typedef enum int {IDLE_RECV_HEAVY, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;
    typedef enum int {OPS_FULL, OPS_RISE, OPS_FALL, OPS_SMALL} row_style_t;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 135;
    localparam logic [psmr_pkg::PART_W-1:0] PHASE_PART [PHASES] = '{
        16'd1, 16'd2, 16'd0, 16'd3, 16'd65535, 16'd5, 16'd1, 16'd1024
    };

    localparam int DIRECTED_ROWS = 18;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{32'sd12345, 16'sd3, -16'sd7, 1'b0, 1'b1}, 1'b1, '{-32'sd21, 1'b0, 32'd0}},
        '{'{32'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1, '{32'sd0, 1'b0, 32'd0}},
        '{'{32'sd0, 16'sh8000, 16'sh8000, 1'b1, 1'b1}, 1'b1,
          '{32'sd1073741824, 1'b0, 32'd0}},
        '{'{32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1}, 1'b1,
          '{32'sh7FFF_FFFF, 1'b1, 32'd1}},
        '{'{32'sh8000_0000, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1}, 1'b1,
          '{32'sh8000_0000, 1'b1, 32'd2}},
        '{'{-32'sd1, -16'sd1, -16'sd1, 1'b1, 1'b1}, 1'b1, '{32'sd0, 1'b0, 32'd2}},
        '{'{-32'sd1, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1}, 1'b0, '0},
        '{'{32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 16'sh8000, 16'sh8000, 1'b0, 1'b1}, 1'b0, '0},
        '{'{32'sh5555_5555, 16'sh5555, 16'shAAAA, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'shAAAA_AAAA, 16'shAAAA, 16'sh5555, 1'b0, 1'b1}, 1'b0, '0},
        '{'{32'sd100, 16'sd5, 16'sd5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{-32'sd200, 16'sd2, 16'sd3, 1'b1, 1'b1}, 1'b0, '0},
        '{'{32'sh8000_0000, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 16'sd1, 16'sd1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{32'sh7FFF_FFFF, 16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [psmr_pkg::PART_W-1:0] cfg_wdata;

    psmr_in_if  items_ch ();
    psmr_out_if results_ch ();

    partitioned_saturating_mac_row dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (items_ch),
        .results   (results_ch)
    );

    longint                       acc_sum = 0;
    logic [psmr_pkg::PART_W-1:0]  part_count = '0;
    logic                         row_clamp_seen = 1'b0;
    logic [psmr_pkg::TOTAL_W-1:0] clamp_events = '0;
    logic [psmr_pkg::PART_W-1:0]  part_size_shadow = psmr_pkg::PART_SIZE_RST;

    row_out_t pending_rows [$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void saturate_sum();
        if (acc_sum > SUM_MAX)
            acc_sum = SUM_MAX;
        else if (acc_sum < SUM_MIN)
            acc_sum = SUM_MIN;
        else
            return;
        row_clamp_seen = 1'b1;
        clamp_events++;
    endfunction

    function automatic logic mac_row_step(input mac_item_t item, output row_out_t row);
        int unsigned limit;
        limit = (part_size_shadow == 0) ? psmr_pkg::MAX_PART_SIZE_DEF : part_size_shadow;
        row = '0;
        if (item.first)
        begin
            acc_sum = item.bias;
            part_count = '0;
            row_clamp_seen = 1'b0;
        end
        acc_sum += longint'(item.element) * longint'(item.weight);
        part_count++;
        if (part_count >= limit)
        begin
            saturate_sum();
            part_count = '0;
        end
        if (!item.last)
            return 1'b0;
        saturate_sum();
        row = '{acc_sum[31:0], row_clamp_seen, clamp_events};
        part_count = '0;
        row_clamp_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(input mac_item_t item, input logic typed, input row_out_t want);
        row_out_t predicted;
        logic     produced;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            items_ch.valid <= 1'b0;
            @(negedge clk);
        end
        items_ch.valid         <= 1'b1;
        items_ch.bias_value    <= item.bias;
        items_ch.element_value <= item.element;
        items_ch.weight_value  <= item.weight;
        items_ch.first_of_row  <= item.first;
        items_ch.last_of_row   <= item.last;
        do
            @(posedge clk);
        while (items_ch.ready !== 1'b1);
        produced = mac_row_step(item, predicted);
        if (produced)
            pending_rows.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_results();
        while (pending_rows.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_part_size(input logic [psmr_pkg::PART_W-1:0] value);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        part_size_shadow = value;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_RECV_HEAVY:
            begin
                send_idle_pct = 9;
                recv_idle_pct = 80;
            end
            IDLE_SEND_HEAVY:
            begin
                send_idle_pct = 80;
                recv_idle_pct = 9;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Mostly well-formed rows; a few lose their first or last mark, and a few
    // items get random marks.
    task automatic random_rows(input int unsigned goal);
        int unsigned sent;
        int unsigned len;
        int          mag;
        row_style_t  style;
        logic        drop_first;
        logic        drop_last;
        logic        paused;
        mac_item_t   item;
        sent = 0;
        paused = 1'b0;
        while (sent < goal)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            style = row_style_t'($urandom_range(0, 3));
            drop_first = ($urandom_range(0, 19) == 0);
            drop_last = ($urandom_range(0, 19) == 0);
            for (int unsigned k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 5))
                    0: item.bias = 32'sh7FFF_FFFF;
                    1: item.bias = 32'sh8000_0000;
                    default: item.bias = $urandom;
                endcase
                case (style)
                    OPS_FULL:
                    begin
                        item.element = ELEM_BITS'($urandom);
                        item.weight = WGT_BITS'($urandom);
                    end
                    OPS_SMALL:
                    begin
                        mag = int'($urandom_range(0, 255)) - 128;
                        item.element = ELEM_BITS'(mag);
                        mag = int'($urandom_range(0, 255)) - 128;
                        item.weight = WGT_BITS'(mag);
                    end
                    default:
                    begin
                        mag = $urandom_range(24576, 32767);
                        item.element = ELEM_BITS'(($urandom_range(0, 1) == 1) ? -mag : mag);
                        mag = $urandom_range(24576, 32767);
                        item.weight = WGT_BITS'(((item.element < 0) == (style == OPS_RISE))
                                                ? -mag : mag);
                    end
                endcase
                item.first = (k == 0) && !drop_first;
                item.last = (k == len - 1) && !drop_last;
                if ($urandom_range(0, 29) == 0)
                begin
                    item.first = ($urandom_range(0, 1) == 1);
                    item.last = ($urandom_range(0, 1) == 1);
                end
                send_item(item, 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= goal / 2)
            begin
                paused = 1'b1;
                items_ch.valid <= 1'b0;
                drain_results();
            end
        end
    endtask

    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        row_out_t want;
        row_out_t got;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got = '{results_ch.row_result, results_ch.row_clamped, results_ch.clamp_total};
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing pending: sum %0d clamped %0b total %0d",
                             $time, got.sum, got.clamped, got.total);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (got.sum !== want.sum || got.clamped !== want.clamped
                    || got.total !== want.total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                                 $time, want.sum, want.clamped, want.total,
                                 got.sum, got.clamped, got.total);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        items_ch.valid = 1'b0;
        items_ch.bias_value = '0;
        items_ch.element_value = '0;
        items_ch.weight_value = '0;
        items_ch.first_of_row = 1'b0;
        items_ch.last_of_row = 1'b0;
        set_idle(IDLE_RECV_HEAVY);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
        items_ch.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            set_idle(p < 3 ? IDLE_RECV_HEAVY : (p < 6 ? IDLE_SEND_HEAVY : IDLE_NONE));
            write_part_size(PHASE_PART[p]);
            random_rows(PHASE_ITEMS);
            items_ch.valid <= 1'b0;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
